FILE: sv/teg_pkg.sv
package teg_pkg;

    localparam logic [2:0] PH_STOP   = 3'd0;
    localparam logic [2:0] PH_ATTACK = 3'd1;
    localparam logic [2:0] PH_HOLD   = 3'd2;
    localparam logic [2:0] PH_REL    = 3'd3;
    localparam logic [2:0] PH_DIRECT = 3'd4;

    localparam logic [1:0] MODE_WRITE   = 2'd0;
    localparam logic [1:0] MODE_START   = 2'd1;
    localparam logic [1:0] MODE_TICK    = 2'd2;
    localparam logic [1:0] MODE_RELEASE = 2'd3;

    localparam logic [3:0] CRV_LOOP = 4'hd;
    localparam logic [3:0] CRV_HOLD = 4'he;
    localparam logic [3:0] CRV_STOP = 4'hf;

    localparam logic [2:0] REG_RATE     = 3'd0;
    localparam logic [2:0] REG_OFFSET   = 3'd1;
    localparam logic [2:0] REG_SCALE    = 3'd2;
    localparam logic [2:0] REG_DIRECT   = 3'd3;
    localparam logic [2:0] REG_TABLE    = 3'd4;
    localparam logic [2:0] REG_REL_PRES = 3'd5;
    localparam logic [2:0] REG_REL_BASE = 3'd6;

    localparam logic [15:0] FULL_LEVEL = 16'h7fff;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_WRITE,
        OP_START,
        OP_RD,
        OP_START_APPLY,
        OP_INC,
        OP_REL_DIRECT,
        OP_SET_STOP,
        OP_REL_SETUP,
        OP_REL_APPLY,
        OP_SET_REL,
        OP_SET_HOLD,
        OP_TARGET,
        OP_DIRECT_END,
        OP_WALK_INIT,
        OP_CROSS,
        OP_CMD,
        OP_DIV_LOAD_PT,
        OP_DIV_LOAD_DIR,
        OP_DIV_STEP,
        OP_CURVE,
        OP_LERP,
        OP_SCALE,
        OP_OUT_LOAD
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   rel_base;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] phase;
        logic       table_on;
        logic       rel_on;
        logic       rel_base_zero;
        logic       direct_on;
        logic       ge_point;
        logic       lt_direct;
        logic       walk_full;
        logic [3:0] rd_curve;
        logic       div_last;
        logic       out_free;
    } dp_status_t;

    function automatic logic [15:0] curve_point(input logic [1:0] sel, input logic [4:0] idx);
        logic [15:0] v;
        v = 16'd0;
        case (sel)
            2'd0: v = (idx >= 5'd16) ? 16'd0 : 16'(32768 - 2048 * int'(idx));
            2'd1:
                case (idx)
                    5'd0: v = 16'd32768;  5'd1: v = 16'd31727;  5'd2: v = 16'd30652;
                    5'd3: v = 16'd29537;  5'd4: v = 16'd28378;  5'd5: v = 16'd27170;
                    5'd6: v = 16'd25905;  5'd7: v = 16'd24576;  5'd8: v = 16'd23170;
                    5'd9: v = 16'd21674;  5'd10: v = 16'd20066; 5'd11: v = 16'd18318;
                    5'd12: v = 16'd16384; 5'd13: v = 16'd14189; 5'd14: v = 16'd11585;
                    5'd15: v = 16'd8192;  default: v = 16'd0;
                endcase
            2'd2:
                case (idx)
                    5'd0: v = 16'd32768;  5'd1: v = 16'd28800;  5'd2: v = 16'd25088;
                    5'd3: v = 16'd21632;  5'd4: v = 16'd18432;  5'd5: v = 16'd15488;
                    5'd6: v = 16'd12800;  5'd7: v = 16'd10368;  5'd8: v = 16'd8192;
                    5'd9: v = 16'd6272;   5'd10: v = 16'd4608;  5'd11: v = 16'd3200;
                    5'd12: v = 16'd2048;  5'd13: v = 16'd1152;  5'd14: v = 16'd512;
                    5'd15: v = 16'd128;   default: v = 16'd0;
                endcase
            default:
                case (idx)
                    5'd0: v = 16'd32768;  5'd1: v = 16'd31801;  5'd2: v = 16'd25601;
                    5'd3: v = 16'd17901;  5'd4: v = 16'd13100;  5'd5: v = 16'd9480;
                    5'd6: v = 16'd6950;   5'd7: v = 16'd5160;   5'd8: v = 16'd3690;
                    5'd9: v = 16'd2680;   5'd10: v = 16'd1900;  5'd11: v = 16'd1430;
                    5'd12: v = 16'd1010;  5'd13: v = 16'd777;   5'd14: v = 16'd500;
                    5'd15: v = 16'd300;   default: v = 16'd0;
                endcase
        endcase
        return v;
    endfunction

    function automatic logic [1:0] map_curve(input logic [3:0] c);
        return (c <= 4'd3) ? c[1:0] : 2'd0;
    endfunction

endpackage

FILE: sv/table_envelope_generator_unit.sv
// A point write stores its point and an idle tick goes straight to scaling. A live
// tick also walks any segment boundaries crossed, and the curve position within a
// running segment comes from a 16-step serial divider before interpolation.
// One word is processed at a time; the next is accepted once the result is registered.
// Reset: control, envelope state and configuration registers go to their defaults;
// the point memory is not cleared and holds garbage until written.
module table_envelope_generator_unit #(
    parameter int POINT_DEPTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [4:0]         point_index,
    input  logic [3:0]         point_curve,
    input  logic [14:0]        point_duration,
    input  logic signed [15:0] point_target,
    input  logic [15:0]        tick_delta,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] value,
    output logic signed [15:0] level,
    output logic [2:0]         phase
);
    import teg_pkg::*;

    localparam int IW = (POINT_DEPTH > 1) ? $clog2(POINT_DEPTH) : 1;

    dp_cmd_t    cmd;
    dp_status_t status;

    teg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    teg_datapath #(
        .POINT_DEPTH (POINT_DEPTH),
        .IW          (IW)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mode           (mode),
        .point_index    (point_index),
        .point_curve    (point_curve),
        .point_duration (point_duration),
        .point_target   (point_target),
        .tick_delta     (tick_delta),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .value          (value),
        .level          (level),
        .phase          (phase)
    );

endmodule

FILE: sv/teg_datapath.sv
module teg_datapath #(
    parameter int POINT_DEPTH = 32,
    parameter int IW = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  teg_pkg::dp_cmd_t    cmd,
    output teg_pkg::dp_status_t status,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic [1:0]          mode,
    input  logic [4:0]          point_index,
    input  logic [3:0]          point_curve,
    input  logic [14:0]         point_duration,
    input  logic signed [15:0]  point_target,
    input  logic [15:0]         tick_delta,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [15:0]  value,
    output logic signed [15:0]  level,
    output logic [2:0]          phase
);
    import teg_pkg::*;

    localparam bit IS_POW2 = (POINT_DEPTH & (POINT_DEPTH - 1)) == 0;
    localparam logic [39:0] MRECIP = 40'((64'd1 << 24) / POINT_DEPTH);
    localparam logic [16:0] DEPTH_C = 17'(POINT_DEPTH);
    localparam int NW = $clog2(POINT_DEPTH + 1);

    // Reduction modulo the depth: a mask for powers of two, otherwise a
    // reciprocal multiply with a single correcting subtract.
    function automatic logic [IW-1:0] wrap_idx(input logic [15:0] x);
        logic [39:0] p;
        logic [16:0] q;
        logic [16:0] r;
        p = 40'(x) * MRECIP;
        q = {1'b0, p[39:24]};
        r = {1'b0, x} - 17'(q * DEPTH_C);
        if (r >= DEPTH_C) begin
            r = r - DEPTH_C;
        end
        return IS_POW2 ? x[IW-1:0] : r[IW-1:0];
    endfunction

    // configuration
    logic [15:0]        rate_reg;
    logic signed [15:0] offset_reg;
    logic signed [15:0] scale_reg;
    logic [15:0]        direct_reg;
    logic               table_reg;
    logic               rel_pres_reg;
    logic [4:0]         rel_base_reg;

    // latched input word
    logic [1:0]         mode_reg;
    logic [4:0]         idx_reg;
    logic [3:0]         curve_in_reg;
    logic [14:0]        dur_in_reg;
    logic signed [15:0] tgt_in_reg;
    logic [15:0]        delta_reg;

    // envelope state
    logic [23:0]        elapsed_reg;
    logic [IW-1:0]      seg_reg;
    logic signed [15:0] cur_reg;
    logic signed [15:0] start_reg;
    logic signed [15:0] target_reg;
    logic [1:0]         csel_reg;
    logic [2:0]         phase_reg;
    logic [NW-1:0]      n_reg;

    // point memory
    logic [34:0]        mem [POINT_DEPTH];
    logic [34:0]        rd_reg;

    // divider and arithmetic
    logic [15:0]        rem_reg;
    logic [15:0]        num_reg;
    logic [15:0]        quo_reg;
    logic [14:0]        div_d_reg;
    logic [3:0]         div_cnt_reg;
    logic [15:0]        c_reg;
    logic signed [15:0] value_reg;

    logic               out_valid_reg;
    logic signed [15:0] out_value_reg;
    logic signed [15:0] out_level_reg;
    logic [2:0]         out_phase_reg;

    logic [3:0]         rd_curve;
    logic [14:0]        rd_dur;
    logic signed [15:0] rd_tgt;
    logic [4:0]         base_sel;
    logic [IW-1:0]      rd_addr;
    logic [IW-1:0]      wr_addr;
    logic [16:0]        div_trial;
    logic [31:0]        inc_prod;
    logic [24:0]        inc_sum;
    logic [29:0]        curve_sum;
    logic signed [33:0] lerp_sum;
    logic signed [33:0] lerp_shift;
    logic signed [31:0] scale_prod;
    logic signed [31:0] scale_shift;
    logic signed [24:0] value_sum;
    logic [15:0]        t_lo;
    logic [15:0]        t_hi;
    logic [12:0]        f_inv;
    logic               out_free;

    assign rd_curve = rd_reg[34:31];
    assign rd_dur   = rd_reg[30:16];
    assign rd_tgt   = rd_reg[15:0];
    assign base_sel = cmd.rel_base ? rel_base_reg : 5'd0;
    assign rd_addr  = wrap_idx(16'(base_sel) + 16'(seg_reg));
    assign wr_addr  = wrap_idx(16'(idx_reg));
    assign div_trial = {rem_reg, num_reg[15]};
    assign inc_prod = delta_reg * rate_reg;
    assign inc_sum  = {1'b0, elapsed_reg} + {1'b0, inc_prod[31:8]};
    assign t_lo     = curve_point(csel_reg, {1'b0, quo_reg[15:12]});
    assign t_hi     = curve_point(csel_reg, 5'({1'b0, quo_reg[15:12]} + 5'd1));
    assign f_inv    = 13'd4096 - {1'b0, quo_reg[11:0]};
    assign curve_sum = 30'(f_inv) * 30'(t_lo) + 30'(quo_reg[11:0]) * 30'(t_hi);
    assign lerp_sum = 34'(start_reg) * 34'($signed({1'b0, c_reg}))
                    + 34'(target_reg) * 34'($signed(17'd32768 - {1'b0, c_reg}));
    assign lerp_shift = lerp_sum >>> 15;
    assign scale_prod = cur_reg * scale_reg;
    assign scale_shift = scale_prod >>> 8;
    assign value_sum = 25'(offset_reg) + 25'(scale_shift);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        status.mode          = mode_reg;
        status.phase         = phase_reg;
        status.table_on      = table_reg;
        status.rel_on        = rel_pres_reg;
        status.rel_base_zero = (rel_base_reg == 5'd0);
        status.direct_on     = (direct_reg != 16'd0);
        status.ge_point      = (elapsed_reg >= {1'b0, rd_dur, 8'd0});
        status.lt_direct     = (elapsed_reg < {2'b0, direct_reg[13:0], 8'd0});
        status.walk_full     = (n_reg == NW'(POINT_DEPTH));
        status.rd_curve      = rd_curve;
        status.div_last      = (div_cnt_reg == 4'd15);
        status.out_free      = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg     <= 16'd256;
            offset_reg   <= 16'sd0;
            scale_reg    <= 16'sd256;
            direct_reg   <= 16'd0;
            table_reg    <= 1'b0;
            rel_pres_reg <= 1'b0;
            rel_base_reg <= 5'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RATE:     rate_reg     <= cfg_data;
                REG_OFFSET:   offset_reg   <= cfg_data;
                REG_SCALE:    scale_reg    <= cfg_data;
                REG_DIRECT:   direct_reg   <= cfg_data;
                REG_TABLE:    table_reg    <= cfg_data[0];
                REG_REL_PRES: rel_pres_reg <= cfg_data[0];
                REG_REL_BASE: rel_base_reg <= cfg_data[4:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_WRITE)
        begin
            mem[wr_addr] <= {curve_in_reg, dur_in_reg, tgt_in_reg};
        end
        if (cmd.op == OP_RD)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LATCH:
            begin
                mode_reg     <= mode;
                idx_reg      <= point_index;
                curve_in_reg <= point_curve;
                dur_in_reg   <= point_duration;
                tgt_in_reg   <= point_target;
                delta_reg    <= tick_delta;
            end
            OP_DIV_LOAD_PT, OP_DIV_LOAD_DIR:
            begin
                rem_reg     <= elapsed_reg[23:8];
                num_reg     <= {elapsed_reg[7:0], 8'd0};
                div_d_reg   <= (cmd.op == OP_DIV_LOAD_PT) ? rd_dur : {1'b0, direct_reg[13:0]};
                div_cnt_reg <= 4'd0;
            end
            OP_DIV_STEP:
            begin
                if (div_trial >= {2'b0, div_d_reg})
                begin
                    rem_reg <= 16'(div_trial - {2'b0, div_d_reg});
                    quo_reg <= {quo_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_reg <= div_trial[15:0];
                    quo_reg <= {quo_reg[14:0], 1'b0};
                end
                num_reg     <= {num_reg[14:0], 1'b0};
                div_cnt_reg <= div_cnt_reg + 4'd1;
            end
            OP_CURVE: c_reg <= curve_sum[27:12];
            OP_SCALE:
            begin
                if (value_sum > 25'sd32767)
                begin
                    value_reg <= 16'sh7fff;
                end
                else if (value_sum < -25'sd32768)
                begin
                    value_reg <= 16'sh8000;
                end
                else
                begin
                    value_reg <= value_sum[15:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= 24'd0;
            seg_reg     <= '0;
            cur_reg     <= 16'sd0;
            start_reg   <= 16'sd0;
            target_reg  <= 16'sd0;
            csel_reg    <= 2'd0;
            phase_reg   <= PH_STOP;
            n_reg       <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_START:
                begin
                    elapsed_reg <= 24'd0;
                    seg_reg     <= '0;
                    start_reg   <= 16'sd0;
                    if (table_reg)
                    begin
                        cur_reg <= 16'sd0;
                    end
                    else
                    begin
                        cur_reg   <= FULL_LEVEL;
                        phase_reg <= PH_HOLD;
                    end
                end
                OP_START_APPLY:
                begin
                    target_reg <= rd_tgt;
                    csel_reg   <= map_curve(rd_curve);
                    phase_reg  <= PH_ATTACK;
                end
                OP_INC: elapsed_reg <= inc_sum[24] ? 24'hffffff : inc_sum[23:0];
                OP_REL_DIRECT:
                begin
                    elapsed_reg <= 24'd0;
                    start_reg   <= cur_reg;
                    target_reg  <= 16'sd0;
                    seg_reg     <= '0;
                    csel_reg    <= direct_reg[15:14];
                    phase_reg   <= PH_DIRECT;
                end
                OP_SET_STOP: phase_reg <= PH_STOP;
                OP_REL_SETUP:
                begin
                    elapsed_reg <= 24'd0;
                    start_reg   <= cur_reg;
                    seg_reg     <= '0;
                end
                OP_REL_APPLY:
                begin
                    target_reg <= rd_tgt;
                    csel_reg   <= map_curve(rd_curve);
                    phase_reg  <= PH_REL;
                end
                OP_SET_REL:  phase_reg <= PH_REL;
                OP_SET_HOLD: phase_reg <= PH_HOLD;
                OP_TARGET:   cur_reg <= target_reg;
                OP_DIRECT_END:
                begin
                    cur_reg   <= target_reg;
                    phase_reg <= PH_STOP;
                end
                OP_WALK_INIT: n_reg <= '0;
                OP_CROSS:
                begin
                    n_reg       <= n_reg + NW'(1);
                    elapsed_reg <= elapsed_reg - {1'b0, rd_dur, 8'd0};
                    cur_reg     <= target_reg;
                    start_reg   <= target_reg;
                    seg_reg     <= wrap_idx(16'(seg_reg) + 16'd1);
                end
                OP_CMD:
                begin
                    if (rd_curve == CRV_STOP)
                    begin
                        phase_reg <= PH_STOP;
                    end
                    else if (rd_curve == CRV_HOLD)
                    begin
                        phase_reg <= PH_HOLD;
                    end
                    else if (rd_curve == CRV_LOOP)
                    begin
                        seg_reg <= wrap_idx(rd_tgt);
                    end
                    else
                    begin
                        csel_reg   <= map_curve(rd_curve);
                        target_reg <= rd_tgt;
                    end
                end
                OP_LERP: cur_reg <= lerp_shift[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_OUT_LOAD)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_OUT_LOAD)
        begin
            out_value_reg <= value_reg;
            out_level_reg <= cur_reg;
            out_phase_reg <= phase_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = out_value_reg;
    assign level     = out_level_reg;
    assign phase     = out_phase_reg;

endmodule

FILE: sv/teg_ctrl.sv
module teg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  teg_pkg::dp_status_t status,
    output teg_pkg::dp_cmd_t    cmd
);
    import teg_pkg::*;

    typedef enum logic [21:0] {
        ST_IDLE    = 22'h000001,
        ST_DECODE  = 22'h000002,
        ST_WRITE   = 22'h000004,
        ST_START   = 22'h000008,
        ST_S_RD    = 22'h000010,
        ST_S_APPLY = 22'h000020,
        ST_INC     = 22'h000040,
        ST_REL     = 22'h000080,
        ST_R_RD    = 22'h000100,
        ST_R_APPLY = 22'h000200,
        ST_WALK    = 22'h000400,
        ST_W_RD    = 22'h000800,
        ST_W_CHK   = 22'h001000,
        ST_C_RD    = 22'h002000,
        ST_C_CMD   = 22'h004000,
        ST_DIV     = 22'h008000,
        ST_CURVE   = 22'h010000,
        ST_LERP    = 22'h020000,
        ST_SCALE   = 22'h040000,
        ST_OUT     = 22'h080000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   tick_live;

    assign tick_live = status.phase == PH_ATTACK || status.phase == PH_REL
                    || status.phase == PH_DIRECT;
    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = OP_NONE;
        cmd.rel_base = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (status.mode)
                    MODE_WRITE: state_next = ST_WRITE;
                    MODE_START: state_next = ST_START;
                    MODE_TICK:  state_next = tick_live ? ST_INC : ST_SCALE;
                    default:    state_next = ST_REL;
                endcase
            end
            ST_WRITE:
            begin
                cmd.op     = OP_WRITE;
                state_next = ST_SCALE;
            end
            ST_START:
            begin
                cmd.op     = OP_START;
                state_next = status.table_on ? ST_S_RD : ST_SCALE;
            end
            ST_S_RD:
            begin
                cmd.op     = OP_RD;
                state_next = ST_S_APPLY;
            end
            ST_S_APPLY:
            begin
                cmd.op     = OP_START_APPLY;
                state_next = ST_SCALE;
            end
            ST_INC:
            begin
                cmd.op     = OP_INC;
                state_next = ST_WALK;
            end
            ST_REL:
            begin
                if (status.direct_on)
                begin
                    cmd.op     = OP_REL_DIRECT;
                    state_next = ST_WALK;
                end
                else if (!status.rel_on)
                begin
                    cmd.op     = OP_SET_STOP;
                    state_next = ST_SCALE;
                end
                else if (!(status.table_on && status.rel_base_zero))
                begin
                    cmd.op     = OP_REL_SETUP;
                    state_next = ST_R_RD;
                end
                else
                begin
                    // Shared table: keep the position, switch phase only.
                    cmd.op     = OP_SET_REL;
                    state_next = ST_WALK;
                end
            end
            ST_R_RD:
            begin
                cmd.op       = OP_RD;
                cmd.rel_base = 1'b1;
                state_next   = ST_R_APPLY;
            end
            ST_R_APPLY:
            begin
                cmd.op     = OP_REL_APPLY;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (status.phase == PH_DIRECT)
                begin
                    cmd.op     = status.lt_direct ? OP_DIV_LOAD_DIR : OP_DIRECT_END;
                    state_next = status.lt_direct ? ST_DIV : ST_SCALE;
                end
                else if ((status.phase == PH_ATTACK && !status.table_on)
                      || (status.phase == PH_REL && !status.rel_on))
                begin
                    cmd.op     = OP_SET_HOLD;
                    state_next = ST_SCALE;
                end
                else if (status.phase == PH_ATTACK || status.phase == PH_REL)
                begin
                    cmd.op     = OP_WALK_INIT;
                    state_next = ST_W_RD;
                end
                else
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_W_RD:
            begin
                cmd.op       = OP_RD;
                cmd.rel_base = (status.phase == PH_REL);
                state_next   = ST_W_CHK;
            end
            ST_W_CHK:
            begin
                if (status.ge_point && status.walk_full)
                begin
                    cmd.op     = OP_TARGET;
                    state_next = ST_SCALE;
                end
                else if (status.ge_point)
                begin
                    cmd.op     = OP_CROSS;
                    state_next = ST_C_RD;
                end
                else
                begin
                    cmd.op     = OP_DIV_LOAD_PT;
                    state_next = ST_DIV;
                end
            end
            ST_C_RD:
            begin
                cmd.op       = OP_RD;
                cmd.rel_base = (status.phase == PH_REL);
                state_next   = ST_C_CMD;
            end
            ST_C_CMD:
            begin
                cmd.op = OP_CMD;
                if (status.rd_curve == CRV_STOP || status.rd_curve == CRV_HOLD)
                begin
                    state_next = ST_SCALE;
                end
                else
                begin
                    state_next = ST_W_RD;
                end
            end
            ST_DIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (status.div_last)
                begin
                    state_next = ST_CURVE;
                end
            end
            ST_CURVE:
            begin
                cmd.op     = OP_CURVE;
                state_next = ST_LERP;
            end
            ST_LERP:
            begin
                cmd.op     = OP_LERP;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.op     = OP_SCALE;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_OUT_LOAD;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> state_reg == ST_DECODE)
        else $error("accepted word did not go to decode");

    a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && !status.div_last) |=> state_reg == ST_DIV)
        else $error("divider left early");

    a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT_LOAD) |=> (state_reg == ST_IDLE && status.phase == $past(status.phase)))
        else $error("result load did not finish the word");

    a_scale_before_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && $past(state_reg) != ST_OUT) |-> $past(state_reg) == ST_SCALE)
        else $error("output reached without scaling");

endmodule

FILE: tb/sv/table_envelope_generator_unit_tb.sv
`timescale 1ns / 100ps

module table_envelope_generator_unit_tb;
    import teg_pkg::*;

    localparam int NPTS = 32;
    localparam int STALL_LIMIT = 3000;
    localparam int CRV[4][17] = '{
        '{32768, 30720, 28672, 26624, 24576, 22528, 20480, 18432, 16384,
          14336, 12288, 10240, 8192, 6144, 4096, 2048, 0},
        '{32768, 31727, 30652, 29537, 28378, 27170, 25905, 24576, 23170,
          21674, 20066, 18318, 16384, 14189, 11585, 8192, 0},
        '{32768, 28800, 25088, 21632, 18432, 15488, 12800, 10368, 8192,
          6272, 4608, 3200, 2048, 1152, 512, 128, 0},
        '{32768, 31801, 25601, 17901, 13100, 9480, 6950, 5160, 3690,
          2680, 1900, 1430, 1010, 777, 500, 300, 0}
    };

    typedef struct {
        logic signed [15:0] value;
        logic signed [15:0] level;
        logic [2:0]         phase;
    } env_out_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         mode;
    logic [4:0]         point_index;
    logic [3:0]         point_curve;
    logic [14:0]        point_duration;
    logic signed [15:0] point_target;
    logic [15:0]        tick_delta;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] value;
    logic signed [15:0] level;
    logic [2:0]         phase;

    table_envelope_generator_unit #(.POINT_DEPTH(NPTS)) dut (.*);

    // Shadow of the block's point memory, envelope state and registers.
    logic [3:0]  sh_curve [NPTS];
    logic [14:0] sh_dur [NPTS];
    logic [15:0] sh_tgt [NPTS];
    int unsigned env_elapsed, env_seg, env_csel, env_phase;
    longint      env_cur, env_start, env_target;
    int unsigned rg_rate, rg_direct, rg_table, rg_relp, rg_relbase;
    longint      rg_offset, rg_scale;

    env_out_t envelope_expected[$];
    int errors;
    int items_sent;
    int quiet_cycles;
    int out_hold;
    bit in_idle_on;
    bit out_idle_on;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic int unsigned pidx(int unsigned b, int unsigned i);
        return (b + i) % NPTS;
    endfunction

    function automatic longint sext16(logic [15:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic int unsigned curve_of(logic [3:0] c);
        return (c <= 4'd3) ? int'(c) : 0;
    endfunction

    task automatic env_interp(int unsigned dur);
        longint r, i, f, c;
        if (dur == 0 || longint'(env_elapsed) >= (longint'(dur) << 8)) begin
            env_cur = env_target;
        end
        else begin
            r = (longint'(env_elapsed) << 8) / dur;
            i = (r >> 12) & 15;
            f = r & 4095;
            c = ((4096 - f) * CRV[env_csel][i] + f * CRV[env_csel][i + 1]) >> 12;
            env_cur = (env_start * c + env_target * (32768 - c)) >>> 15;
        end
    endtask

    task automatic env_walk();
        int unsigned b, n, x, k;
        bit present;
        n = 0;
        if (env_phase == PH_DIRECT) begin
            x = rg_direct & 16'h3fff;
            if (env_elapsed < (x << 8)) env_interp(x);
            else
            begin
                env_cur = env_target;
                env_phase = PH_STOP;
            end
            return;
        end
        if (env_phase != PH_ATTACK && env_phase != PH_REL) return;
        present = (env_phase == PH_ATTACK) ? rg_table != 0 : rg_relp != 0;
        b = (env_phase == PH_ATTACK) ? 0 : rg_relbase;
        if (!present) begin
            env_phase = PH_HOLD;
            return;
        end
        while (env_elapsed >= (int'(sh_dur[pidx(b, env_seg)]) << 8)) begin
            if (n >= NPTS) break;
            n++;
            env_elapsed -= int'(sh_dur[pidx(b, env_seg)]) << 8;
            env_cur = env_target;
            env_start = env_cur;
            env_seg = (env_seg + 1) % NPTS;
            k = pidx(b, env_seg);
            if (sh_curve[k] == CRV_STOP) begin
                env_phase = PH_STOP;
                return;
            end
            else if (sh_curve[k] == CRV_HOLD) begin
                env_phase = PH_HOLD;
                return;
            end
            else if (sh_curve[k] == CRV_LOOP) begin
                env_seg = sh_tgt[k] % NPTS;
            end
            else begin
                env_csel = curve_of(sh_curve[k]);
                env_target = sext16(sh_tgt[k]);
            end
        end
        env_interp(sh_dur[pidx(b, env_seg)]);
    endtask

    task automatic predict_envelope(logic [1:0] m, logic [4:0] pi, logic [3:0] pc,
                                    logic [14:0] pd, logic [15:0] pt, logic [15:0] td);
        longint v, s;
        int unsigned k;
        env_out_t o;
        case (m)
            MODE_WRITE:
            begin
                sh_curve[pi] = pc;
                sh_dur[pi] = pd;
                sh_tgt[pi] = pt;
            end
            MODE_START:
            begin
                env_elapsed = 0;
                env_seg = 0;
                env_cur = 0;
                env_start = 0;
                if (rg_table == 0) begin
                    env_phase = PH_HOLD;
                    env_cur = 32767;
                end
                else begin
                    env_target = sext16(sh_tgt[0]);
                    env_csel = curve_of(sh_curve[0]);
                    env_phase = PH_ATTACK;
                end
            end
            MODE_TICK:
            begin
                if (env_phase == PH_ATTACK || env_phase == PH_REL || env_phase == PH_DIRECT)
                begin
                    s = longint'(env_elapsed) + ((longint'(td) * rg_rate) >> 8);
                    env_elapsed = (s > 24'hffffff) ? 24'hffffff : int'(s);
                    env_walk();
                end
            end
            default:
            begin
                if (rg_direct != 0) begin
                    env_elapsed = 0;
                    env_start = env_cur;
                    env_target = 0;
                    env_seg = 0;
                    env_csel = (rg_direct >> 14) & 3;
                    env_phase = PH_DIRECT;
                    env_walk();
                end
                else if (rg_relp == 0) begin
                    env_phase = PH_STOP;
                end
                else begin
                    if (!(rg_table != 0 && rg_relbase == 0)) begin
                        k = pidx(rg_relbase, 0);
                        env_elapsed = 0;
                        env_start = env_cur;
                        env_target = sext16(sh_tgt[k]);
                        env_seg = 0;
                        env_csel = curve_of(sh_curve[k]);
                    end
                    env_phase = PH_REL;
                    env_walk();
                end
            end
        endcase
        v = rg_offset + ((env_cur * rg_scale) >>> 8);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        o.value = v[15:0];
        o.level = env_cur[15:0];
        o.phase = env_phase[2:0];
        envelope_expected.push_back(o);
    endtask

    task automatic send_word(logic [1:0] m, logic [4:0] pi, logic [3:0] pc,
                             logic [14:0] pd, logic [15:0] pt, logic [15:0] td);
        int gap;
        gap = in_idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        mode = m;
        point_index = pi;
        point_curve = pc;
        point_duration = pd;
        point_target = pt;
        tick_delta = td;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        predict_envelope(m, pi, pc, pd, pt, td);
        items_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_point(int pi, logic [3:0] pc, int pd, logic [15:0] pt);
        send_word(MODE_WRITE, pi[4:0], pc, pd[14:0], pt, 16'($urandom));
    endtask

    task automatic tick(logic [15:0] td);
        send_word(MODE_TICK, 5'($urandom), 4'($urandom), 15'($urandom), 16'($urandom), td);
    endtask

    task automatic start_env();
        send_word(MODE_START, 5'($urandom), 4'($urandom), 15'($urandom), 16'($urandom),
                  16'($urandom));
    endtask

    task automatic release_env();
        send_word(MODE_RELEASE, 5'($urandom), 4'($urandom), 15'($urandom), 16'($urandom),
                  16'($urandom));
    endtask

    // Registers change only with nothing in flight; a point write stores its point before
    // its result leaves, so the extra cycles are only margin.
    task automatic wait_drained();
        while (envelope_expected.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] d);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = d;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_RATE:     rg_rate = d;
            REG_OFFSET:   rg_offset = sext16(d);
            REG_SCALE:    rg_scale = sext16(d);
            REG_DIRECT:   rg_direct = d;
            REG_TABLE:    rg_table = d[0];
            REG_REL_PRES: rg_relp = d[0];
            default:      rg_relbase = d[4:0];
        endcase
    endtask

    task automatic set_regs(logic [15:0] rate, logic [15:0] off, logic [15:0] scl,
                            logic [15:0] dir, bit tab, bit relp, logic [4:0] rb);
        wait_drained();
        write_reg(REG_RATE, rate);
        write_reg(REG_OFFSET, off);
        write_reg(REG_SCALE, scl);
        write_reg(REG_DIRECT, dir);
        write_reg(REG_TABLE, {15'd0, tab});
        write_reg(REG_REL_PRES, {15'd0, relp});
        write_reg(REG_REL_BASE, {11'd0, rb});
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_point(int pi);
        int c, d;
        c = $urandom_range(0, 15);
        if (c > 12 && $urandom_range(0, 2) != 0) c = $urandom_range(0, 3);
        d = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 300);
        write_point(pi, c[3:0], d, 16'($urandom));
    endtask

    function automatic logic [15:0] random_delta();
        case ($urandom_range(0, 7))
            0: return 16'($urandom);
            1: return 16'h0000;
            default: return 16'($urandom_range(0, 8000));
        endcase
    endfunction

    task automatic test_fill_points();
        for (int i = 0; i < NPTS; i++) random_point(i);
    endtask

    task automatic test_directed();
        // Hold at full level when there is no attack table; release with nothing stops.
        set_regs(16'd256, 16'h0000, 16'd256, 16'h0000, 1'b0, 1'b0, 5'd16);
        start_env();
        tick(16'hffff);
        release_env();
        // Attack: a short first segment, then zero-duration segments and a loop back
        // to them that runs into the walk limit on one tick.
        write_point(0, 4'd0, 4, 16'h7fff);
        write_point(1, 4'd2, 0, 16'h8000);
        write_point(2, 4'd7, 0, 16'h1234);
        write_point(3, CRV_LOOP, 9, 16'h0001);
        set_regs(16'hffff, 16'h7fff, 16'h8000, 16'h0000, 1'b1, 1'b0, 5'd16);
        start_env();
        tick(16'h0001);
        tick(16'h0000);
        tick(16'hffff);
        // A hold command inside the table, then the shared-table release.
        write_point(1, 4'd3, 20, 16'h4000);
        write_point(2, CRV_HOLD, 0, 16'h0000);
        set_regs(16'd256, 16'h8000, 16'h7fff, 16'h0000, 1'b1, 1'b1, 5'd0);
        start_env();
        tick(16'd1000);
        tick(16'hffff);
        release_env();
        tick(16'd3000);
        // Direct release with the largest word and a release sub-table at the top.
        write_point(31, CRV_STOP, 5, 16'hffff);
        set_regs(16'd256, 16'h0000, 16'd256, 16'hffff, 1'b1, 1'b1, 5'd31);
        start_env();
        tick(16'd500);
        release_env();
        tick(16'hffff);
        wait_drained();
        write_reg(REG_DIRECT, 16'h0000);
        start_env();
        release_env();
        tick(16'd2000);
    endtask

    task automatic test_random_phase(int n_items);
        int stop_at, r, k;
        stop_at = items_sent + n_items;
        in_idle_on = $urandom_range(0, 3) != 0;
        out_idle_on = $urandom_range(0, 3) != 0;
        set_regs(($urandom_range(0, 3) == 0) ? pick16() : 16'($urandom_range(64, 1024)),
                 pick16(), pick16(),
                 ($urandom_range(0, 2) == 0) ? pick16() : 16'h0000,
                 $urandom_range(0, 5) != 0, $urandom_range(0, 1), 5'($urandom));
        while (items_sent < stop_at) begin
            r = $urandom_range(0, 9);
            if (r < 2) begin
                random_point($urandom_range(0, NPTS - 1));
            end
            else if (r == 2) begin
                send_word(2'($urandom), 5'($urandom), 4'($urandom), 15'($urandom),
                          16'($urandom), 16'($urandom));
            end
            else begin
                start_env();
                k = $urandom_range(1, 8);
                repeat (k) tick(random_delta());
                if ($urandom_range(0, 3) != 0) release_env();
                k = $urandom_range(0, 6);
                repeat (k) tick(random_delta());
            end
        end
    endtask

    // Result checker.
    always @(posedge clk) begin
        env_out_t e;
        if (out_valid && !out_stall) begin
            out_hold <= out_idle_on ? $urandom_range(0, 14) : 0;
            if (envelope_expected.size() == 0) begin
                $display("%0t: unexpected word value=%0d level=%0d phase=%0d",
                         $time, value, level, phase);
                errors++;
            end
            else begin
                e = envelope_expected.pop_front();
                if (value !== e.value) begin
                    $display("%0t: value expected %0d actual %0d", $time, e.value, value);
                    errors++;
                end
                if (level !== e.level) begin
                    $display("%0t: level expected %0d actual %0d", $time, e.level, level);
                    errors++;
                end
                if (phase !== e.phase) begin
                    $display("%0t: phase expected %0d actual %0d", $time, e.phase, phase);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk) begin
        if (out_hold > 0) begin
            out_stall <= 1'b1;
            out_hold <= out_hold - 1;
        end
        else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("table_envelope_generator_unit_tb: FAIL");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        mode = MODE_WRITE;
        point_index = '0;
        point_curve = '0;
        point_duration = '0;
        point_target = '0;
        tick_delta = '0;
        out_stall = 1'b0;
        out_hold = 0;
        errors = 0;
        items_sent = 0;
        quiet_cycles = 0;
        in_idle_on = 1'b1;
        out_idle_on = 1'b1;
        env_elapsed = 0;
        env_seg = 0;
        env_csel = 0;
        env_phase = PH_STOP;
        env_cur = 0;
        env_start = 0;
        env_target = 0;
        rg_rate = 256;
        rg_offset = 0;
        rg_scale = 256;
        rg_direct = 0;
        rg_table = 0;
        rg_relp = 0;
        rg_relbase = 16;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_fill_points();
        test_directed();
        for (int p = 0; p < 6; p++) test_random_phase(150);

        while (envelope_expected.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        if (errors == 0) begin
            $display("table_envelope_generator_unit_tb: PASS");
        end
        else begin
            $display("table_envelope_generator_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: table_envelope_generator_unit.f
sv/teg_pkg.sv
sv/teg_datapath.sv
sv/teg_ctrl.sv
sv/table_envelope_generator_unit.sv
tb/sv/table_envelope_generator_unit_tb.sv
